/* rtl/text_line_folder_unit_assert.svh */
// ---------------------------------------------------------------------------
// text_line_folder_unit_assert.svh
// Assertion macros shared by the line folder checks. Clock clk, reset rst.
// ---------------------------------------------------------------------------
`ifndef TEXT_LINE_FOLDER_UNIT_ASSERT_SVH
`define TEXT_LINE_FOLDER_UNIT_ASSERT_SVH

// Condition that must hold on every edge out of reset
`define TLF_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication
`define TLF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define TLF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/tlf_pkg.sv */
// ---------------------------------------------------------------------------
// tlf_pkg
// Constants shared by the line folder and its checker.
// ---------------------------------------------------------------------------
package tlf_pkg;

  // Word buffer depth default
  localparam int WORD_DEPTH_DEF = 32;

  // Character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TAB_WIDTH  = 1'b1;

  // Register reset values and legal bounds
  localparam logic [4:0] LINE_WIDTH_RST = 5'd20;
  localparam logic [4:0] TAB_WIDTH_RST  = 5'd8;
  localparam logic [4:0] LINE_WIDTH_MIN = 5'd8;
  localparam logic [4:0] TAB_WIDTH_MAX  = 5'd16;

  // Pending blank count saturation
  localparam logic [5:0] BLANK_MAX = 6'd63;

endpackage

/* rtl/text_line_folder_unit.sv */
// ---------------------------------------------------------------------------
// text_line_folder_unit
// Word-wrapping line folder: one text byte in, zero or more bytes out.
// ---------------------------------------------------------------------------
// s_tready is high only in idle, where a word byte with room in the buffer is stored at once.
// Word flush from a blank: accept, dispatch, remainder steps, then tabs and spaces if it fits
//   or a newline if it wraps (a long word skips both), read and write per word byte, hyphen
//   and newline per break, closing; a tab then adds remainder and add steps, a newline its
//   byte. Full buffer: no blanks. Bare space: dispatch; tab: remainder, add; newline: its byte.
// Reset clears column, blank count, word length, output valid, not the word buffer; widths 20, 8.
module text_line_folder_unit #(
  parameter int WORD_DEPTH = tlf_pkg::WORD_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] in_byte
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // [7:0] out_byte
  output logic                           m_tlast,   // last
  input  logic                           cfg_wr_en,
  input  logic [tlf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlf_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IW = $clog2(WORD_DEPTH);
  localparam int LW = $clog2(WORD_DEPTH + 1);

  // Sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_MOD     = 4'd2;
  localparam logic [3:0] S_ADD     = 4'd3;
  localparam logic [3:0] S_TABS    = 4'd4;
  localparam logic [3:0] S_SPACES  = 4'd5;
  localparam logic [3:0] S_NLFIRST = 4'd6;
  localparam logic [3:0] S_RD      = 4'd7;
  localparam logic [3:0] S_WORD    = 4'd8;
  localparam logic [3:0] S_HYPH    = 4'd9;
  localparam logic [3:0] S_BRNL    = 4'd10;
  localparam logic [3:0] S_POST    = 4'd11;
  localparam logic [3:0] S_NL      = 4'd12;

  // Registers
  logic [3:0]    state, state_next;
  logic [4:0]    line_width, tab_width;
  logic [4:0]    column, column_next;
  logic [5:0]    pending, pending_next;
  logic [LW-1:0] wl, wl_next;
  logic [IW-1:0] idx, idx_next;
  logic          long_mode, long_mode_next;
  logic [7:0]    cur, cur_next;
  logic [4:0]    gap, gap_next;
  logic [4:0]    rem, rem_next;
  logic [6:0]    dvd, dvd_next;
  logic [2:0]    cnt, cnt_next;
  logic          mod_to_tabs, mod_to_tabs_next;
  logic [7:0]    rdata;
  logic          out_valid;
  logic [7:0]    out_byte;
  logic          out_last;

  logic [7:0]    word_mem [WORD_DEPTH];

  // Combinational signals
  logic          accept, can_emit, emit, emit_last;
  logic [7:0]    emit_byte;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [4:0]    lw_eff, tw_eff;
  logic          in_blank, cur_blank;
  logic [7:0]    fit_sum, lw8, wl8;
  logic [4:0]    rem_shift, rem_step;
  logic [6:0]    blank_sum;
  logic          word_end;
  logic [5:0]    col_p1;

  // Effective register values
  always_comb begin
    lw_eff = (line_width < tlf_pkg::LINE_WIDTH_MIN) ? tlf_pkg::LINE_WIDTH_MIN : line_width;
    if (tab_width == 5'd0) begin
      tw_eff = 5'd1;
    end else if (tab_width > tlf_pkg::TAB_WIDTH_MAX) begin
      tw_eff = tlf_pkg::TAB_WIDTH_MAX;
    end else begin
      tw_eff = tab_width;
    end
  end

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == S_IDLE);
  assign can_emit  = !out_valid || m_tready;
  assign in_blank  = (s_tdata == tlf_pkg::CH_TAB) || (s_tdata == tlf_pkg::CH_SPACE) ||
                     (s_tdata == tlf_pkg::CH_NL);
  assign cur_blank = (cur == tlf_pkg::CH_TAB) || (cur == tlf_pkg::CH_SPACE) ||
                     (cur == tlf_pkg::CH_NL);

  // Fit check: column + blanks + word against the line
  assign fit_sum = 8'(column) + 8'(pending) + 8'(wl);
  assign lw8     = 8'(lw_eff);
  assign wl8     = 8'(wl);

  // Shared remainder unit: one restoring step per cycle
  assign rem_shift = {rem[3:0], dvd[cnt]};
  assign rem_step  = (rem_shift >= tw_eff) ? (rem_shift - tw_eff) : rem_shift;

  assign blank_sum = 7'(pending) + 7'(gap);
  assign word_end  = (LW'(idx) == (wl - LW'(1)));
  assign col_p1    = 6'(column) + 6'd1;

  // Sequencer
  always_comb begin
    state_next       = state;
    column_next      = column;
    pending_next     = pending;
    wl_next          = wl;
    idx_next         = idx;
    long_mode_next   = long_mode;
    cur_next         = cur;
    gap_next         = gap;
    rem_next         = rem;
    dvd_next         = dvd;
    cnt_next         = cnt;
    mod_to_tabs_next = mod_to_tabs;
    emit             = 1'b0;
    emit_byte        = rdata;
    emit_last        = 1'b0;
    mem_we           = 1'b0;
    mem_waddr        = wl[IW-1:0];
    mem_wdata        = s_tdata;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cur_next = s_tdata;
          if (!in_blank && (wl != LW'(WORD_DEPTH))) begin
            mem_we  = 1'b1;
            wl_next = wl + LW'(1);
          end else begin
            state_next = S_DISP;
          end
        end
      end

      S_DISP: begin
        idx_next = '0;
        if (!cur_blank) begin
          // full buffer: write it out in long-word style
          long_mode_next = 1'b1;
          state_next     = S_RD;
        end else if (wl != '0) begin
          if (wl8 > lw8) begin
            long_mode_next = 1'b1;
            state_next     = S_RD;
          end else if (fit_sum > lw8) begin
            long_mode_next = 1'b0;
            pending_next   = '0;
            state_next     = S_NLFIRST;
          end else begin
            long_mode_next   = 1'b0;
            dvd_next         = 7'(column);
            cnt_next         = 3'd6;
            rem_next         = '0;
            mod_to_tabs_next = 1'b1;
            state_next       = S_MOD;
          end
        end else if (cur == tlf_pkg::CH_SPACE) begin
          pending_next = (pending == tlf_pkg::BLANK_MAX) ? pending : pending + 6'd1;
          state_next   = S_IDLE;
        end else if (cur == tlf_pkg::CH_TAB) begin
          dvd_next         = 7'(column) + 7'(pending);
          cnt_next         = 3'd6;
          rem_next         = '0;
          mod_to_tabs_next = 1'b0;
          state_next       = S_MOD;
        end else begin
          state_next = S_NL;
        end
      end

      S_MOD: begin
        rem_next = rem_step;
        cnt_next = cnt - 3'd1;
        if (cnt == 3'd0) begin
          gap_next   = tw_eff - rem_step;
          state_next = mod_to_tabs ? S_TABS : S_ADD;
        end
      end

      S_ADD: begin
        pending_next = (blank_sum > 7'(tlf_pkg::BLANK_MAX)) ? tlf_pkg::BLANK_MAX :
                       blank_sum[5:0];
        state_next   = S_IDLE;
      end

      S_TABS: begin
        if (pending >= 6'(gap)) begin
          if (can_emit) begin
            emit         = 1'b1;
            emit_byte    = tlf_pkg::CH_TAB;
            pending_next = pending - 6'(gap);
            column_next  = column + gap;
            gap_next     = tw_eff;
          end
        end else begin
          state_next = S_SPACES;
        end
      end

      S_SPACES: begin
        if (pending != '0) begin
          if (can_emit) begin
            emit         = 1'b1;
            emit_byte    = tlf_pkg::CH_SPACE;
            pending_next = pending - 6'd1;
            column_next  = column + 5'd1;
          end
        end else begin
          state_next = S_RD;
        end
      end

      S_NLFIRST: begin
        if (can_emit) begin
          emit        = 1'b1;
          emit_byte   = tlf_pkg::CH_NL;
          column_next = '0;
          state_next  = S_RD;
        end
      end

      S_RD: begin
        state_next = S_WORD;
      end

      S_WORD: begin
        if (long_mode && (col_p1 >= 6'(lw_eff))) begin
          state_next = S_HYPH;
        end else if (can_emit) begin
          emit        = 1'b1;
          emit_last   = word_end && (cur != tlf_pkg::CH_NL);
          column_next = column + 5'd1;
          idx_next    = idx + IW'(1);
          state_next  = word_end ? S_POST : S_RD;
        end
      end

      S_HYPH: begin
        if (can_emit) begin
          emit       = 1'b1;
          emit_byte  = tlf_pkg::CH_HYPHEN;
          state_next = S_BRNL;
        end
      end

      S_BRNL: begin
        if (can_emit) begin
          emit        = 1'b1;
          emit_byte   = tlf_pkg::CH_NL;
          column_next = '0;
          state_next  = S_WORD;
        end
      end

      S_POST: begin
        wl_next        = '0;
        pending_next   = '0;
        long_mode_next = 1'b0;
        if (!cur_blank) begin
          // start a new word with the byte that found the buffer full
          mem_we     = 1'b1;
          mem_waddr  = '0;
          mem_wdata  = cur;
          wl_next    = LW'(1);
          state_next = S_IDLE;
        end else if (cur == tlf_pkg::CH_SPACE) begin
          pending_next = 6'd1;
          state_next   = S_IDLE;
        end else if (cur == tlf_pkg::CH_TAB) begin
          dvd_next         = 7'(column);
          cnt_next         = 3'd6;
          rem_next         = '0;
          mod_to_tabs_next = 1'b0;
          state_next       = S_MOD;
        end else begin
          state_next = S_NL;
        end
      end

      S_NL: begin
        if (can_emit) begin
          emit         = 1'b1;
          emit_byte    = tlf_pkg::CH_NL;
          emit_last    = 1'b1;
          column_next  = '0;
          pending_next = '0;
          state_next   = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      column     <= '0;
      pending    <= '0;
      wl         <= '0;
      long_mode  <= 1'b0;
      line_width <= tlf_pkg::LINE_WIDTH_RST;
      tab_width  <= tlf_pkg::TAB_WIDTH_RST;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      column    <= column_next;
      pending   <= pending_next;
      wl        <= wl_next;
      long_mode <= long_mode_next;
      if (cfg_wr_en) begin
        if (cfg_index == tlf_pkg::REG_LINE_WIDTH) begin
          line_width <= cfg_data;
        end else begin
          tab_width <= cfg_data;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    idx         <= idx_next;
    cur         <= cur_next;
    gap         <= gap_next;
    rem         <= rem_next;
    dvd         <= dvd_next;
    cnt         <= cnt_next;
    mod_to_tabs <= mod_to_tabs_next;
    if (emit) begin
      out_byte <= emit_byte;
      out_last <= emit_last;
    end
  end

  // Word buffer
  always_ff @(posedge clk) begin
    if (mem_we) begin
      word_mem[mem_waddr] <= mem_wdata;
    end
    if (state == S_RD) begin
      rdata <= word_mem[idx];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tlast  = out_last;

endmodule

/* rtl/tlf_checker.sv */
// ---------------------------------------------------------------------------
// tlf_checker
// Port-level checks on the line folder, bound to every text_line_folder_unit.
// ---------------------------------------------------------------------------
`include "text_line_folder_unit_assert.svh"

module tlf_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,   // [7:0] out_byte
  input logic       m_tlast    // last
);

  logic       out_stall;
  logic [8:0] out_word;
  logic       out_tab;
  logic       out_space;

  assign out_stall = m_tvalid && !m_tready;
  assign out_word  = {m_tlast, m_tdata};
  assign out_tab   = m_tvalid && (m_tdata == tlf_pkg::CH_TAB);
  assign out_space = m_tvalid && (m_tdata == tlf_pkg::CH_SPACE);

  // Stalled output request holds
  `TLF_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(out_word), "stall not held")

  // Tabs and spaces only come before a word byte, never end a request
  `TLF_ASSERT_IMPL(a_tab_not_last, out_tab, !m_tlast, "tab marked last")
  `TLF_ASSERT_IMPL(a_space_not_last, out_space, !m_tlast, "space marked last")

  // An idle folder with an empty output stage produces nothing next cycle
  `TLF_ASSERT_NEXT(a_idle_quiet, s_tready && !m_tvalid, !m_tvalid, "output while idle")

endmodule

bind text_line_folder_unit tlf_checker u_tlf_checker (.*);
